>>> sv/mpe_pkg.sv
// ---------------------------------------------------------------------------
// mpe_pkg
// shared widths, request codes and register indexes of the polynomial evaluator
// ---------------------------------------------------------------------------
package mpe_pkg;

    localparam int REQ_W   = 3;
    localparam int TERM_W  = 6;
    localparam int ROW_W   = 6;
    localparam int VAR_W   = 3;
    localparam int EXPIN_W = 4;
    localparam int DATA_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [REQ_W-1:0] REQ_COEF  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ROW   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_EXP   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RANGE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_VALUE = 3'd4;
    localparam logic [REQ_W-1:0] REQ_EVAL  = 3'd5;
    // unused codes, ignored by the block
    localparam logic [REQ_W-1:0] REQ_RSVD_A = 3'd6;
    localparam logic [REQ_W-1:0] REQ_RSVD_B = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_TERMS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VARS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN  = 2'd2;

    localparam int TERMS_CFG_W = 7;
    localparam int VARS_CFG_W  = 4;

    // q16.16 one
    localparam logic signed [DATA_W-1:0] ONE_Q = 32'sd65536;

endpackage

>>> sv/mpe_req_if.sv
// ---------------------------------------------------------------------------
// mpe_req_if
// request channel: loader items and evaluate items
// ---------------------------------------------------------------------------
interface mpe_req_if;
    logic                                 valid;
    logic                                 ready;
    logic [mpe_pkg::REQ_W-1:0]            req_type;
    logic [mpe_pkg::TERM_W-1:0]           term_index;
    logic [mpe_pkg::ROW_W-1:0]            row_index;
    logic [mpe_pkg::VAR_W-1:0]            var_index;
    logic [mpe_pkg::EXPIN_W-1:0]          exponent;
    logic signed [mpe_pkg::DATA_W-1:0]    value_a;
    logic signed [mpe_pkg::DATA_W-1:0]    value_b;

    modport source (output valid, req_type, term_index, row_index, var_index, exponent,
                    value_a, value_b, input ready);
    modport sink   (input valid, req_type, term_index, row_index, var_index, exponent,
                    value_a, value_b, output ready);
endinterface

>>> sv/mpe_res_if.sv
// ---------------------------------------------------------------------------
// mpe_res_if
// result channel: evaluated polynomial and overflow flag
// ---------------------------------------------------------------------------
interface mpe_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [mpe_pkg::DATA_W-1:0] poly_value;
    logic                              overflow;

    modport source (output valid, poly_value, overflow, input ready);
    modport sink   (input valid, poly_value, overflow, output ready);
endinterface

>>> sv/mpe_ram.sv
// ---------------------------------------------------------------------------
// mpe_ram
// simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module mpe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/multivariate_polynomial_eval.sv
// ---------------------------------------------------------------------------
// multivariate_polynomial_eval
// evaluates a fitted multivariate polynomial in signed q16.16
// ---------------------------------------------------------------------------
// i_req carries one item per handshake: loads of coefficients, term rows,
// exponents, variable ranges and values, or an evaluate request. A load is
// written into its table in the cycle it is accepted and returns nothing.
// An evaluate item returns one item on o_res (poly_value, overflow).
// Configuration (terms, vars, mean) is written through i_cfg_we/idx/data.
// Evaluation first maps every variable through a bit-serial divider, then
// walks the terms: per term it reads the coefficient and row, per variable
// the exponent, then runs the shared multiply/round pair once per power
// step beyond the first and once to scale the term; the ram read latency
// and this shared pair set the pace. i_req.ready is high only while no
// evaluation runs. The result sits in an output register, so a stalled
// receiver only holds the next evaluation at its end. Reset is synchronous,
// active low: it clears control state, counters and configuration; tables
// and datapath registers stay unknown until written.
// ---------------------------------------------------------------------------
module multivariate_polynomial_eval #(
    parameter int MAX_TERMS    = 64,
    parameter int MAX_VARS     = 8,
    parameter int MAX_ROWS     = 64,
    parameter int MAX_EXPONENT = 15
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mpe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mpe_pkg::DATA_W-1:0]        i_cfg_data,
    mpe_req_if.sink                           i_req,
    mpe_res_if.source                         o_res
);
    localparam int TA_W   = MAX_TERMS > 1 ? $clog2(MAX_TERMS) : 1;
    localparam int TC_W   = $clog2(MAX_TERMS + 1);
    localparam int VA_W   = MAX_VARS > 1 ? $clog2(MAX_VARS) : 1;
    localparam int VC_W   = $clog2(MAX_VARS + 1);
    localparam int E_DEPTH = MAX_ROWS * MAX_VARS;
    localparam int EA_W   = E_DEPTH > 1 ? $clog2(E_DEPTH) : 1;
    localparam int EXP_W  = $clog2(MAX_EXPONENT + 1);
    localparam int SUM_W  = mpe_pkg::DATA_W + TC_W + 1;
    localparam int NUM_W  = 51;
    localparam int DEN_W  = 34;
    localparam int CNT_W  = 6;
    localparam int DW     = mpe_pkg::DATA_W;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_MAP   = 11'b00000000010,
        S_DIV   = 11'b00000000100,
        S_MAPWR = 11'b00000001000,
        S_TADDR = 11'b00000010000,
        S_TLOAD = 11'b00000100000,
        S_EADDR = 11'b00001000000,
        S_EDATA = 11'b00010000000,
        S_STEP  = 11'b00100000000,
        S_RND   = 11'b01000000000,
        S_FINAL = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [mpe_pkg::TERMS_CFG_W-1:0] r_terms;
    logic [mpe_pkg::VARS_CFG_W-1:0]  r_vars;
    logic signed [DW-1:0]            r_mean;

    // per variable tables
    logic signed [DW-1:0] r_vmin [MAX_VARS];
    logic signed [DW-1:0] r_vmax [MAX_VARS];
    logic signed [DW-1:0] r_vval [MAX_VARS];
    logic signed [DW-1:0] r_v    [MAX_VARS];
    logic                 r_vsat [MAX_VARS];

    // evaluation datapath
    logic [TC_W-1:0]         r_i, n_i;
    logic [VC_W-1:0]         r_j, n_j;
    logic [mpe_pkg::ROW_W-1:0] r_row, n_row;
    logic [EXP_W-1:0]        r_e, n_e, r_k, n_k;
    logic signed [DW-1:0]    r_term, n_term, r_r, n_r;
    logic signed [2*DW-1:0]  r_prod, n_prod;
    logic                    r_pow, n_pow;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                    r_flag, n_flag, r_zero, n_zero;
    logic [NUM_W-1:0]        r_num, n_num;
    logic [DEN_W-1:0]        r_den, n_den, r_rem, n_rem;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_neg, n_neg;

    // output register
    logic                    r_out_valid, n_out_valid;
    logic signed [DW-1:0]    r_out_value, n_out_value;
    logic                    r_out_ovf, n_out_ovf;

    logic [TC_W-1:0] nt;
    logic [VC_W-1:0] nv;
    logic            req_fire;
    logic            out_free;

    // memories
    logic             coef_we, row_we, exp_we;
    logic [TA_W-1:0]  t_waddr;
    logic [EA_W-1:0]  e_waddr, e_raddr;
    logic [EXP_W-1:0] e_wdata, e_rdata;
    logic [DW-1:0]    coef_rdata;
    logic [mpe_pkg::ROW_W-1:0] row_rdata;

    logic [VA_W-1:0]  j_idx, wv_idx;
    logic             wv_ok;

    // combinational helpers
    logic signed [DW:0]     x_diff;
    logic signed [DW+1:0]   n_val;
    logic signed [DW:0]     d_val;
    logic [DW+1:0]          n_mag;
    logic [DW:0]            d_mag;
    logic [DEN_W:0]         rem_sh;
    logic                   q_bit;
    logic signed [NUM_W+1:0] v_full;
    logic signed [DW-1:0]   v_sat;
    logic                   v_is_sat;
    logic [2*DW-1:0]        p_mag;
    logic [2*DW-17:0]       p_rnd;
    logic signed [2*DW-16:0] p_sgn;
    logic signed [DW-1:0]   p_res;
    logic                   p_sat;
    logic signed [DW-1:0]   s_res;
    logic                   s_sat;
    logic [EXP_W-1:0]       e_eff;

    assign nt = (32'(r_terms) > 32'(MAX_TERMS)) ? TC_W'(MAX_TERMS) : TC_W'(r_terms);
    assign nv = (32'(r_vars) > 32'(MAX_VARS)) ? VC_W'(MAX_VARS) : VC_W'(r_vars);

    assign i_req.ready = (r_state == S_IDLE);
    assign req_fire    = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_res.ready;

    assign o_res.valid      = r_out_valid;
    assign o_res.poly_value = r_out_value;
    assign o_res.overflow   = r_out_ovf;

    // table writes
    assign t_waddr = TA_W'(i_req.term_index);
    assign coef_we = req_fire && i_req.req_type == mpe_pkg::REQ_COEF
                     && 32'(i_req.term_index) < 32'(MAX_TERMS);
    assign row_we  = req_fire && i_req.req_type == mpe_pkg::REQ_ROW
                     && 32'(i_req.term_index) < 32'(MAX_TERMS);
    assign exp_we  = req_fire && i_req.req_type == mpe_pkg::REQ_EXP
                     && 32'(i_req.row_index) < 32'(MAX_ROWS)
                     && 32'(i_req.var_index) < 32'(MAX_VARS);
    assign e_waddr = EA_W'(32'(i_req.row_index) * 32'(MAX_VARS) + 32'(i_req.var_index));
    assign e_wdata = (32'(i_req.exponent) > 32'(MAX_EXPONENT)) ? EXP_W'(MAX_EXPONENT)
                                                               : EXP_W'(i_req.exponent);
    assign e_raddr = EA_W'(32'(r_row) * 32'(MAX_VARS) + 32'(r_j));
    assign wv_idx  = VA_W'(i_req.var_index);
    assign wv_ok   = 32'(i_req.var_index) < 32'(MAX_VARS);
    assign j_idx   = r_j[VA_W-1:0];

    mpe_ram #(.WIDTH(DW), .DEPTH(MAX_TERMS)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (coef_we),
        .i_waddr (t_waddr),
        .i_wdata (i_req.value_a),
        .i_raddr (r_i[TA_W-1:0]),
        .o_rdata (coef_rdata)
    );

    mpe_ram #(.WIDTH(mpe_pkg::ROW_W), .DEPTH(MAX_TERMS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (t_waddr),
        .i_wdata (i_req.row_index),
        .i_raddr (r_i[TA_W-1:0]),
        .o_rdata (row_rdata)
    );

    mpe_ram #(.WIDTH(EXP_W), .DEPTH(E_DEPTH)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (exp_we),
        .i_waddr (e_waddr),
        .i_wdata (e_wdata),
        .i_raddr (e_raddr),
        .o_rdata (e_rdata)
    );

    // per variable register tables, one write index, one read index
    always_ff @(posedge i_clk) begin
        if (req_fire && wv_ok && i_req.req_type == mpe_pkg::REQ_RANGE) begin
            r_vmin[wv_idx] <= i_req.value_a;
            r_vmax[wv_idx] <= i_req.value_b;
        end
        if (req_fire && wv_ok && i_req.req_type == mpe_pkg::REQ_VALUE) begin
            r_vval[wv_idx] <= i_req.value_a;
        end
        if (r_state == S_MAP && r_j < nv && d_val == '0) begin
            r_v[j_idx]    <= '0;
            r_vsat[j_idx] <= 1'b0;
        end
        if (r_state == S_MAPWR) begin
            r_v[j_idx]    <= v_sat;
            r_vsat[j_idx] <= v_is_sat;
        end
    end

    // mapping arithmetic: n = 2*(x - max), d = max - min
    always_comb begin
        x_diff = 33'(r_vval[j_idx]) - 33'(r_vmax[j_idx]);
        n_val  = {x_diff, 1'b0};
        d_val  = 33'(r_vmax[j_idx]) - 33'(r_vmin[j_idx]);
        n_mag  = n_val[DW+1] ? 34'(-n_val) : 34'(n_val);
        d_mag  = d_val[DW] ? 33'(-d_val) : 33'(d_val);
        // one quotient bit per cycle
        rem_sh = {r_rem, r_num[NUM_W-1]};
        q_bit  = rem_sh >= {1'b0, r_den};
        // v = one +/- q, saturated
        v_full = r_neg ? (53'(mpe_pkg::ONE_Q) - 53'({1'b0, r_num}))
                       : (53'(mpe_pkg::ONE_Q) + 53'({1'b0, r_num}));
        v_is_sat = v_full > 53'sd2147483647 || v_full < -53'sd2147483648;
        v_sat    = v_full > 53'sd2147483647 ? 32'sh7fffffff
                 : (v_full < -53'sd2147483648 ? 32'sh80000000 : DW'(v_full));
    end

    // product rounding: nearest, ties away from zero, then saturate
    always_comb begin
        p_mag = r_prod[2*DW-1] ? 64'(-r_prod) : 64'(r_prod);
        p_rnd = 48'((p_mag + 64'd32768) >> 16);
        p_sgn = r_prod[2*DW-1] ? -$signed({1'b0, p_rnd}) : $signed({1'b0, p_rnd});
        p_sat = p_sgn > 49'sd2147483647 || p_sgn < -49'sd2147483648;
        p_res = p_sgn > 49'sd2147483647 ? 32'sh7fffffff
              : (p_sgn < -49'sd2147483648 ? 32'sh80000000 : DW'(p_sgn));
        s_sat = r_sum > SUM_W'(64'sd2147483647) || r_sum < SUM_W'(-64'sd2147483648);
        s_res = r_sum > SUM_W'(64'sd2147483647) ? 32'sh7fffffff
              : (r_sum < SUM_W'(-64'sd2147483648) ? 32'sh80000000 : DW'(r_sum));
        e_eff = (32'(r_row) < 32'(MAX_ROWS)) ? e_rdata : '0;
    end

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_j         = r_j;
        n_row       = r_row;
        n_e         = r_e;
        n_k         = r_k;
        n_term      = r_term;
        n_r         = r_r;
        n_prod      = r_prod;
        n_pow       = r_pow;
        n_sum       = r_sum;
        n_flag      = r_flag;
        n_zero      = r_zero;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_neg       = r_neg;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_value = r_out_value;
        n_out_ovf   = r_out_ovf;

        case (r_state)
            S_IDLE: begin
                if (req_fire && i_req.req_type == mpe_pkg::REQ_EVAL) begin
                    n_j     = '0;
                    n_i     = '0;
                    n_zero  = 1'b0;
                    n_flag  = 1'b0;
                    n_sum   = SUM_W'(r_mean);
                    n_state = S_MAP;
                end
            end
            S_MAP: begin
                if (r_j >= nv) begin
                    n_state = S_TADDR;
                end else if (d_val == '0) begin
                    n_zero = 1'b1;
                    n_j    = r_j + 1'b1;
                end else begin
                    // round(n*65536/d) = floor((2*|n|*65536 + |d|) / (2*|d|))
                    n_num   = (NUM_W'(n_mag) << 17) + NUM_W'(d_mag);
                    n_den   = {d_mag, 1'b0};
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_neg   = n_val[DW+1] != d_val[DW];
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = q_bit ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
                n_num = {r_num[NUM_W-2:0], q_bit};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = S_MAPWR;
                end
            end
            S_MAPWR: begin
                n_j     = r_j + 1'b1;
                n_state = S_MAP;
            end
            S_TADDR: begin
                if (r_i >= nt) begin
                    n_state = S_FINAL;
                end else begin
                    n_state = S_TLOAD;
                end
            end
            S_TLOAD: begin
                n_term  = coef_rdata;
                n_row   = row_rdata;
                n_j     = '0;
                n_state = S_EADDR;
            end
            S_EADDR: begin
                if (r_j >= nv) begin
                    n_sum   = r_sum + SUM_W'(r_term);
                    n_i     = r_i + 1'b1;
                    n_state = S_TADDR;
                end else begin
                    n_state = S_EDATA;
                end
            end
            S_EDATA: begin
                n_e = e_eff;
                n_k = EXP_W'(2);
                if (e_eff == '0) begin
                    n_r = '0;
                end else if (e_eff == EXP_W'(1)) begin
                    n_r = mpe_pkg::ONE_Q;
                end else begin
                    n_r    = r_v[j_idx];
                    n_flag = r_flag || r_vsat[j_idx];
                end
                n_state = S_STEP;
            end
            S_STEP: begin
                if (r_k < r_e) begin
                    n_prod = r_r * r_v[j_idx];
                    n_pow  = 1'b1;
                end else begin
                    n_prod = r_term * r_r;
                    n_pow  = 1'b0;
                end
                n_state = S_RND;
            end
            S_RND: begin
                n_flag = r_flag || p_sat;
                if (r_pow) begin
                    n_r     = p_res;
                    n_k     = r_k + 1'b1;
                    n_state = S_STEP;
                end else begin
                    n_term  = p_res;
                    n_j     = r_j + 1'b1;
                    n_state = S_EADDR;
                end
            end
            S_FINAL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = s_res;
                    n_out_ovf   = r_flag || s_sat || (r_zero && nt != '0);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_terms     <= '0;
            r_vars      <= mpe_pkg::VARS_CFG_W'(1);
            r_mean      <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_e         <= '0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_i         <= n_i;
            r_j         <= n_j;
            r_k         <= n_k;
            r_e         <= n_e;
            r_cnt       <= n_cnt;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mpe_pkg::CFG_TERMS: r_terms <= i_cfg_data[mpe_pkg::TERMS_CFG_W-1:0];
                    mpe_pkg::CFG_VARS:  r_vars  <= i_cfg_data[mpe_pkg::VARS_CFG_W-1:0];
                    mpe_pkg::CFG_MEAN:  r_mean  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_row       <= n_row;
        r_term      <= n_term;
        r_r         <= n_r;
        r_prod      <= n_prod;
        r_pow       <= n_pow;
        r_sum       <= n_sum;
        r_flag      <= n_flag;
        r_zero      <= n_zero;
        r_num       <= n_num;
        r_den       <= n_den;
        r_rem       <= n_rem;
        r_neg       <= n_neg;
        r_out_value <= n_out_value;
        r_out_ovf   <= n_out_ovf;
    end

    // a finished evaluation always lands in the output register
    a_final_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL && out_free) |=> o_res.valid)
        else $error("evaluation result lost");

    // divider never runs past the numerator width
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt < CNT_W'(NUM_W)))
        else $error("divider overran");

    // exponent reads only happen for variables in use
    a_var_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDATA) |-> (r_j < nv))
        else $error("variable index beyond vars in use");

    // power loop never overshoots the exponent
    a_pow_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RND && r_pow) |-> (r_k < r_e))
        else $error("power step beyond exponent");

endmodule

>>> test/mpe_checker.sv
// ---------------------------------------------------------------------------
// mpe_checker
// tracks the evaluator's tables and registers, predicts each evaluate result
// and compares it field by field with what leaves the result channel
// ---------------------------------------------------------------------------
module mpe_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mpe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mpe_pkg::DATA_W-1:0]        i_cfg_data,
    mpe_req_if                                i_req,
    mpe_res_if                                i_res,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_evals,
    output int                                o_overflows
);
    localparam int N_TERMS = 64;
    localparam int N_VARS  = 8;
    localparam int N_ROWS  = 64;
    localparam int EXP_TOP = 15;
    localparam longint I32_HI = 64'sd2147483647;
    localparam longint I32_LO = -64'sd2147483648;

    typedef struct {
        logic signed [mpe_pkg::DATA_W-1:0] poly_value;
        logic                              overflow;
    } t_poly_result;

    logic signed [mpe_pkg::DATA_W-1:0]  coef_tbl[N_TERMS];
    logic [mpe_pkg::ROW_W-1:0]          term_row_tbl[N_TERMS];
    logic [mpe_pkg::EXPIN_W-1:0]        exp_tbl[N_ROWS*N_VARS];
    logic signed [mpe_pkg::DATA_W-1:0]  lo_tbl[N_VARS];
    logic signed [mpe_pkg::DATA_W-1:0]  hi_tbl[N_VARS];
    logic signed [mpe_pkg::DATA_W-1:0]  x_tbl[N_VARS];
    logic [mpe_pkg::TERMS_CFG_W-1:0]    terms_cfg;
    logic [mpe_pkg::VARS_CFG_W-1:0]     vars_cfg;
    logic signed [mpe_pkg::DATA_W-1:0]  mean_q;

    t_poly_result expected_polys[$];
    int errors, evals, overflows;

    function automatic longint clamp32(input longint x, inout bit flag);
        if (x > I32_HI) begin
            flag = 1;
            return I32_HI;
        end
        if (x < I32_LO) begin
            flag = 1;
            return I32_LO;
        end
        return x;
    endfunction

    // exact product, round half away from zero at 2^-16, saturate
    function automatic longint qmul16(input longint a, input longint b, inout bit flag);
        longint p;
        longint unsigned mag, r;
        p = a * b;
        mag = (p < 0) ? longint'(-p) : longint'(p);
        r = (mag + 64'd32768) >> 16;
        return clamp32((p < 0) ? -longint'(r) : longint'(r), flag);
    endfunction

    // v = 1 + 2*(x - max)/(max - min)
    function automatic longint scaled_var(input int j, output bit zero_rng, output bit vsat);
        longint n, d;
        longint unsigned nm, dm, q;
        bit flag;
        flag = 0;
        zero_rng = 0;
        n = 2 * (longint'(x_tbl[j]) - longint'(hi_tbl[j]));
        d = longint'(hi_tbl[j]) - longint'(lo_tbl[j]);
        if (d == 0) begin
            zero_rng = 1;
            vsat = 0;
            return 0;
        end
        nm = (n < 0) ? longint'(-n) : longint'(n);
        dm = (d < 0) ? longint'(-d) : longint'(d);
        nm = nm << 16;
        q = (2 * nm + dm) / (2 * dm);
        n = clamp32(65536 + (((n < 0) != (d < 0)) ? -longint'(q) : longint'(q)), flag);
        vsat = flag;
        return n;
    endfunction

    function automatic t_poly_result predict_poly();
        t_poly_result res;
        longint v[N_VARS];
        bit vsat[N_VARS];
        bit flag, zr;
        int nt, nv, row, e;
        longint sum, term, r;
        flag = 0;
        nt = (int'(terms_cfg) > N_TERMS) ? N_TERMS : int'(terms_cfg);
        nv = (int'(vars_cfg) > N_VARS) ? N_VARS : int'(vars_cfg);
        sum = mean_q;
        for (int j = 0; j < nv; j++) begin
            v[j] = scaled_var(j, zr, vsat[j]);
            if (zr && nt > 0) flag = 1;
        end
        for (int i = 0; i < nt; i++) begin
            row = term_row_tbl[i];
            term = coef_tbl[i];
            for (int j = 0; j < nv; j++) begin
                e = (row < N_ROWS) ? exp_tbl[row*N_VARS+j] : 0;
                if (e == 0) begin
                    r = 0;
                end else if (e == 1) begin
                    r = 65536;
                end else begin
                    if (vsat[j]) flag = 1;
                    r = v[j];
                    for (int k = 2; k < e; k++) r = qmul16(r, v[j], flag);
                end
                term = qmul16(term, r, flag);
            end
            sum += term;
        end
        sum = clamp32(sum, flag);
        res.poly_value = sum[31:0];
        res.overflow = flag;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_poly_result exp_res;
        if (!i_rst_n) begin
            terms_cfg = '0;
            vars_cfg  = 4'd1;
            mean_q    = '0;
            expected_polys.delete();
            errors = 0;
            evals = 0;
            overflows = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    mpe_pkg::CFG_TERMS:
                        terms_cfg = i_cfg_data[mpe_pkg::TERMS_CFG_W-1:0];
                    mpe_pkg::CFG_VARS:
                        vars_cfg  = i_cfg_data[mpe_pkg::VARS_CFG_W-1:0];
                    mpe_pkg::CFG_MEAN:
                        mean_q    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (expected_polys.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("mpe_checker: unexpected result item value=%0d ovf=%0b",
                                 i_res.poly_value, i_res.overflow);
                end else begin
                    exp_res = expected_polys.pop_front();
                    if (i_res.poly_value !== exp_res.poly_value
                        || i_res.overflow !== exp_res.overflow) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mpe_checker: mismatch value exp=%0d got=%0d",
                                      " ovf exp=%0b got=%0b"},
                                     exp_res.poly_value, i_res.poly_value,
                                     exp_res.overflow, i_res.overflow);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                case (i_req.req_type)
                    mpe_pkg::REQ_COEF:
                        coef_tbl[i_req.term_index] = i_req.value_a;
                    mpe_pkg::REQ_ROW:
                        term_row_tbl[i_req.term_index] = i_req.row_index;
                    mpe_pkg::REQ_EXP:
                        exp_tbl[i_req.row_index*N_VARS+i_req.var_index] =
                            mpe_pkg::EXPIN_W'((int'(i_req.exponent) > EXP_TOP)
                                              ? EXP_TOP : int'(i_req.exponent));
                    mpe_pkg::REQ_RANGE: begin
                        lo_tbl[i_req.var_index] = i_req.value_a;
                        hi_tbl[i_req.var_index] = i_req.value_b;
                    end
                    mpe_pkg::REQ_VALUE:
                        x_tbl[i_req.var_index] = i_req.value_a;
                    mpe_pkg::REQ_EVAL: begin
                        exp_res = predict_poly();
                        evals++;
                        if (exp_res.overflow) overflows++;
                        expected_polys = {expected_polys, exp_res};
                    end
                    default: ;
                endcase
            end
        end
        o_errors    <= errors;
        o_pending   <= expected_polys.size();
        o_evals     <= evals;
        o_overflows <= overflows;
    end
endmodule

>>> test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// stimulus for the polynomial evaluator: table fill, directed corner cases,
// then random load and evaluate sequences under changing configurations
// ---------------------------------------------------------------------------
module tb_top;
    localparam int CYCLE_LIMIT = 20000000;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [mpe_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [mpe_pkg::DATA_W-1:0] i_cfg_data = '0;

    mpe_req_if req_ch ();
    mpe_res_if res_ch ();

    int errors, pending, evals, overflows;
    int cycles = 0;
    int burst_left = 0;
    int random_items = 0;
    bit want_hold = 0;

    multivariate_polynomial_eval DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req_ch.sink), .o_res(res_ch.source)
    );

    mpe_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_req(req_ch), .i_res(res_ch), .o_errors(errors),
        .o_pending(pending), .o_evals(evals), .o_overflows(overflows)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        req_ch.valid = 0;
        req_ch.req_type = mpe_pkg::REQ_COEF;
        req_ch.term_index = '0;
        req_ch.row_index = '0;
        req_ch.var_index = '0;
        req_ch.exponent = '0;
        req_ch.value_a = '0;
        req_ch.value_b = '0;
        res_ch.ready = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // receiver: randomly changing stall pattern, plus one long hold
    int rx_mode = 0, rx_left = 0, hold_left = 0;
    always @(posedge i_clk) begin
        if (want_hold && hold_left == 0) begin
            hold_left = 4000;
            want_hold = 0;
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(50, 400);
        end
        rx_left--;
        if (hold_left > 0) begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end else begin
            case (rx_mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= ($urandom_range(0, 1) == 0);
                2: res_ch.ready <= ($urandom_range(0, 7) == 0);
                default: res_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 9))
            0, 1: return $urandom;
            2, 3: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic int unsigned rand_exp();
        int k;
        k = $urandom_range(0, 19);
        if (k < 14) return $urandom_range(0, 2);
        if (k < 19) return $urandom_range(3, 5);
        return $urandom_range(6, 15);
    endfunction

    function automatic logic [mpe_pkg::REQ_W-1:0] rand_unused();
        return ($urandom_range(0, 1) == 0) ? mpe_pkg::REQ_RSVD_A : mpe_pkg::REQ_RSVD_B;
    endfunction

    task automatic send(input logic [mpe_pkg::REQ_W-1:0] rt, input int unsigned ti,
                        input int unsigned ri, input int unsigned vi, input int unsigned ex,
                        input logic signed [31:0] a, input logic signed [31:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.req_type <= rt;
        req_ch.term_index <= ti[mpe_pkg::TERM_W-1:0];
        req_ch.row_index <= ri[mpe_pkg::ROW_W-1:0];
        req_ch.var_index <= vi[mpe_pkg::VAR_W-1:0];
        req_ch.exponent <= ex[mpe_pkg::EXPIN_W-1:0];
        req_ch.value_a <= a;
        req_ch.value_b <= b;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic load_range(input int unsigned vi);
        longint lo, hi;
        int k;
        k = $urandom_range(0, 15);
        lo = longint'(rand_q());
        if (k == 0) hi = lo;                                 // zero range
        else if (k == 1) hi = longint'($signed($urandom));   // wild range
        else hi = lo + longint'($urandom_range(32'h0000_4000, 32'h0010_0000));
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
        if ($urandom_range(0, 5) == 0)
            send(mpe_pkg::REQ_RANGE, $urandom, $urandom, vi, $urandom, 32'(hi), 32'(lo));
        else
            send(mpe_pkg::REQ_RANGE, $urandom, $urandom, vi, $urandom, 32'(lo), 32'(hi));
        // variable value mostly inside its range
        if (k > 1 && $urandom_range(0, 7) != 0)
            send(mpe_pkg::REQ_VALUE, $urandom, $urandom, vi, $urandom,
                 32'(lo + longint'($urandom_range(0, 32'(hi - lo)))), $urandom);
        else
            send(mpe_pkg::REQ_VALUE, $urandom, $urandom, vi, $urandom, rand_q(), $urandom);
    endtask

    task automatic random_load();
        case ($urandom_range(0, 4))
            0: send(mpe_pkg::REQ_COEF, $urandom, $urandom, $urandom, $urandom,
                    rand_q(), $urandom);
            1: send(mpe_pkg::REQ_ROW, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
            2: send(mpe_pkg::REQ_EXP, $urandom, $urandom, $urandom, rand_exp(),
                    $urandom, $urandom);
            default: load_range($urandom);
        endcase
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_cfg(input int unsigned nt, input int unsigned nv,
                             input int unsigned mean);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= mpe_pkg::CFG_TERMS;
        i_cfg_data <= nt;
        @(posedge i_clk);
        i_cfg_idx <= mpe_pkg::CFG_VARS;
        i_cfg_data <= nv;
        @(posedge i_clk);
        i_cfg_idx <= mpe_pkg::CFG_MEAN;
        i_cfg_data <= mean;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int nt, nv;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // fill every table so no evaluate reads an unwritten entry
        for (int t = 0; t < 64; t++) begin
            send(mpe_pkg::REQ_COEF, t, $urandom, $urandom, $urandom, rand_q(), $urandom);
            send(mpe_pkg::REQ_ROW, t, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        for (int r = 0; r < 64; r++)
            for (int j = 0; j < 8; j++)
                send(mpe_pkg::REQ_EXP, $urandom, r, j, rand_exp(), $urandom, $urandom);
        for (int j = 0; j < 8; j++) load_range(j);
        send(mpe_pkg::REQ_EVAL, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        wait_idle();

        // directed: one term at the coefficient extremes, highest power, zero range
        write_cfg(1, 8, 32'h7fff_ffff);
        send(mpe_pkg::REQ_RANGE, 0, 0, 0, 0, 32'sh0000_0000, 32'sh0001_0000);
        send(mpe_pkg::REQ_VALUE, 0, 0, 0, 0, 32'sh0001_0000, 0);
        send(mpe_pkg::REQ_ROW, 0, 63, 0, 0, 0, 0);
        for (int j = 0; j < 8; j++) send(mpe_pkg::REQ_EXP, 0, 63, j, (j == 0) ? 15 : 1, 0, 0);
        send(mpe_pkg::REQ_COEF, 0, 0, 0, 0, 32'sh7fff_ffff, 0);
        send(mpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0);
        send(mpe_pkg::REQ_COEF, 0, 0, 0, 0, 32'sh8000_0000, 0);
        send(mpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0);
        send(mpe_pkg::REQ_RANGE, 0, 0, 5, 0, 32'sh0003_0000, 32'sh0003_0000);
        send(mpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0);
        send(mpe_pkg::REQ_RSVD_A, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        send(mpe_pkg::REQ_RSVD_B, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        wait_idle();
        load_range(5);
        wait_idle();
        write_cfg(0, 8, 32'h8000_0000);
        send(mpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0);
        wait_idle();
        write_cfg(64, 0, 32'h0000_0000);
        send(mpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0);
        wait_idle();
        write_cfg(127, 15, 32'h7fff_ffff);
        send(mpe_pkg::REQ_EVAL, 0, 0, 0, 0, 0, 0);
        wait_idle();

        // random phases: each under a new configuration
        for (int ph = 0; random_items < 360; ph++) begin
            case (ph % 6)
                0: nt = 64;
                1: nt = $urandom_range(65, 127);
                default: nt = $urandom_range(0, 16);
            endcase
            nv = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 8);
            write_cfg(nt, nv, rand_q());
            if (ph == 2) want_hold = 1;
            for (int s = 0; s < 12; s++) begin
                case ($urandom_range(0, 9))
                    0: send(rand_unused(), $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom);
                    1, 2: begin
                        random_load();
                        random_items++;
                    end
                    default: begin
                        repeat ($urandom_range(0, 4)) begin
                            random_load();
                            random_items++;
                        end
                        send(mpe_pkg::REQ_EVAL, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom);
                        random_items++;
                    end
                endcase
            end
            wait_idle();
        end

        $display("tb_top: %0d evaluations checked, %0d with overflow, %0d random items",
                 evals, overflows, random_items);
        if (errors == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: %0d mismatches", errors);
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule
